// ===== rtl/core/stair_pkg.sv =====
`timescale 1ns / 1ps

package stair_pkg;

   // Largest number of test frequencies per channel that the block is built for.
   localparam int MAX_FREQS_DEFAULT = 8;

   // Field widths of the transactions and registers.
   localparam int LEVEL_W     = 4;
   localparam int TRIAL_W     = 6;
   localparam int REV_LIMIT_W = 4;
   localparam int FCOUNT_W    = 4;
   localparam int OPTION_W    = 2;
   localparam int THRESH_W    = 5;
   localparam int POS_W       = 3;
   localparam int DONE_W      = 5;
   localparam int RUN_W       = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 6;

   // The reversal count can dip below zero when the reversal limit is set
   // below two; it is kept in two's complement with room for a whole frequency.
   localparam int REV_W = 8;

   // Register reset values.
   localparam logic [LEVEL_W-1:0]     TOP_LEVEL_RESET      = 4'd8;
   localparam logic [LEVEL_W-1:0]     FLOOR_LEVEL_RESET    = 4'd0;
   localparam logic [TRIAL_W-1:0]     TRIAL_LIMIT_RESET    = 6'd50;
   localparam logic [REV_LIMIT_W-1:0] REVERSAL_LIMIT_RESET = 4'd3;
   localparam logic                   WRONG_RUN_EN_RESET   = 1'b0;
   localparam logic [FCOUNT_W-1:0]    FREQ_COUNT_RESET     = 4'd4;

   // Constants of the staircase rules.
   localparam logic [RUN_W-1:0]    WRONG_RUN_END   = 2'd3;
   localparam logic [REV_W:0]      REVERSAL_MARGIN = 9'd2;
   localparam logic [TRIAL_W-1:0]  TRIAL_SAT       = 6'd63;
   localparam logic [REV_W-1:0]    REVERSAL_SAT    = 8'd15;
   localparam logic [DONE_W-1:0]   DONE_SAT        = 5'd31;
   localparam logic [OPTION_W-1:0] NO_ANSWER       = 2'd3;

   // Item kinds.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TRIAL = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOP_LEVEL      = 3'd0,
      CSR_FLOOR_LEVEL    = 3'd1,
      CSR_TRIAL_LIMIT    = 3'd2,
      CSR_REVERSAL_LIMIT = 3'd3,
      CSR_WRONG_RUN_EN   = 3'd4,
      CSR_FREQ_COUNT     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                kind;
      logic [OPTION_W-1:0] asked_option;
      logic [OPTION_W-1:0] response_option;
   } req_item_type;

   typedef struct packed {
      logic                accepted;
      logic                answer_correct;
      logic [LEVEL_W-1:0]  trial_level;
      logic [LEVEL_W-1:0]  next_level;
      logic                frequency_done;
      logic [THRESH_W-1:0] threshold_level;
      logic [POS_W-1:0]    freq_position;
      logic                channel_right;
      logic                test_done;
      logic [DONE_W-1:0]   completed_count;
   } rsp_item_type;

endpackage

// ===== rtl/core/audiometry_staircase_sequencer_top.sv =====
`timescale 1ns / 1ps

// Adaptive up-down staircase sequencer for a hearing test. A start transaction
// (kind 0) arms the test at the first frequency of the left ear; each trial
// transaction (kind 1) carries the option slot that held the tone and the
// listener's choice, and produces exactly one result transaction with the level
// used, the level for the next tone and, when the frequency finishes, its
// threshold and the next frequency and ear. A correct answer lowers the level
// index by one, a wrong one raises it, saturating at zero and at top_level. A
// frequency ends on the floor level, the trial limit, level zero, the reversal
// limit or, if enabled, three wrong answers in a row. The block takes one
// transaction per clock cycle while the result is not stalled; the edge that
// accepts a request loads the input register, a later edge moves it into the
// result register once that is empty or being emptied, and the result is
// presented from then on. The staircase state is updated in the same cycle that
// the result register is loaded, so consecutive trials see each other's effect with no gap.
// The input register can still take one transaction while a finished result is
// stalled, so up to two transactions are held inside. Configuration registers
// may be written at any edge but should only change while no transaction is held.
module audiometry_staircase_sequencer_top
   import stair_pkg::*;
#(
   parameter int MAX_FREQS = MAX_FREQS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [OPTION_W-1:0]    req_asked_option,
   input  logic [OPTION_W-1:0]    req_response_option,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_accepted,
   output logic                   rsp_answer_correct,
   output logic [LEVEL_W-1:0]     rsp_trial_level,
   output logic [LEVEL_W-1:0]     rsp_next_level,
   output logic                   rsp_frequency_done,
   output logic [THRESH_W-1:0]    rsp_threshold_level,
   output logic [POS_W-1:0]       rsp_freq_position,
   output logic                   rsp_channel_right,
   output logic                   rsp_test_done,
   output logic [DONE_W-1:0]      rsp_completed_count
);

   // The frequency index holds at most MAX_FREQS - 1; its increment reaches MAX_FREQS.
   localparam int FIDX_W = (MAX_FREQS > 1) ? $clog2(MAX_FREQS + 1) : 1;
   localparam logic [DONE_W-1:0] MAX_FREQS_V = DONE_W'(MAX_FREQS);

   // Configuration registers.
   logic [LEVEL_W-1:0]     top_level_ff;
   logic [LEVEL_W-1:0]     floor_level_ff;
   logic [TRIAL_W-1:0]     trial_limit_ff;
   logic [REV_LIMIT_W-1:0] reversal_limit_ff;
   logic                   wrong_run_en_ff;
   logic [FCOUNT_W-1:0]    freq_count_ff;

   // Staircase state.
   logic                   active_ff, active_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic [TRIAL_W-1:0]     trial_count_ff, trial_count_in;
   logic                   down_now_ff, down_now_in;
   logic                   down_before_ff, down_before_in;
   logic signed [REV_W-1:0] reversal_ff, reversal_in;
   logic [RUN_W-1:0]       wrong_run_ff, wrong_run_in;
   logic [FIDX_W-1:0]      freq_index_ff, freq_index_in;
   logic                   right_ff, right_in;
   logic [DONE_W-1:0]      done_count_ff, done_count_in;

   // Input and result stages.
   logic                   in_valid_ff, in_valid_in;
   req_item_type           in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   rsp_item_type           out_item_ff, out_item_in;

   logic                   req_take;
   logic                   stage_take;
   logic                   rsp_take;

   // Working values of one trial.
   logic                   correct;
   logic [LEVEL_W-1:0]     moved_level;
   logic                   moved_down;
   logic signed [REV_W-1:0] moved_reversal;
   logic signed [REV_W:0]  rev_plus_margin;
   logic                   margin_hit;
   logic                   rev_below_sat;
   logic [RUN_W-1:0]       run_next;
   logic [TRIAL_W-1:0]     trial_next;
   logic                   freq_end;
   logic [DONE_W-1:0]      nfreq;
   logic [DONE_W-1:0]      fidx_inc;
   logic [DONE_W-1:0]      fidx_after;
   logic [DONE_W-1:0]      done_inc;

   // ------------------------------------------------------------------
   // Handshake. The input register refills as soon as its transaction
   // moves into the result register, which may happen while the result
   // register is being emptied in the same cycle.
   // ------------------------------------------------------------------
   assign rsp_take   = out_valid_ff && !rsp_stall;
   assign stage_take = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (stage_take) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (stage_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Staircase step: one trial or start transaction against the state.
   // ------------------------------------------------------------------
   always_comb begin
      // Answer and wrong-answer run.
      correct = (in_item_ff.response_option != NO_ANSWER) &&
                (in_item_ff.response_option == in_item_ff.asked_option);
      if (correct) begin
         run_next = '0;
      end else if (wrong_run_ff < WRONG_RUN_END) begin
         run_next = wrong_run_ff + 2'd1;
      end else begin
         run_next = wrong_run_ff;
      end
      trial_next = (trial_count_ff < TRIAL_SAT) ? trial_count_ff + 6'd1 : trial_count_ff;

      // Level step; the direction only changes when the level really moves.
      moved_level = level_ff;
      moved_down  = down_now_ff;
      if (correct) begin
         if (level_ff != '0) begin
            moved_level = level_ff - 4'd1;
            moved_down  = 1'b1;
         end
      end else if (level_ff < top_level_ff) begin
         moved_level = level_ff + 4'd1;
         moved_down  = 1'b0;
      end

      // Reversal count, compared as the unsigned word it would be if it went negative.
      rev_below_sat   = !reversal_ff[REV_W-1] && (reversal_ff < $signed(REVERSAL_SAT));
      rev_plus_margin = $signed({reversal_ff[REV_W-1], reversal_ff}) +
                        $signed(REVERSAL_MARGIN);
      margin_hit      = rev_plus_margin[REV_W] ||
                        (rev_plus_margin > $signed({5'b0, reversal_limit_ff}));
      moved_reversal  = reversal_ff;
      if (down_before_ff && !moved_down) begin
         if (rev_below_sat) begin
            moved_reversal = reversal_ff + 8'sd1;
         end
      end else if (down_before_ff && moved_down) begin
         if (margin_hit) begin
            moved_reversal = reversal_ff - 8'sd1;
         end
      end

      freq_end = (moved_level <= floor_level_ff) || (trial_next >= trial_limit_ff) ||
                 (moved_level == '0) ||
                 (moved_reversal == $signed({4'b0, reversal_limit_ff})) ||
                 (wrong_run_en_ff && (run_next >= WRONG_RUN_END));

      // Frequency sequencing with the count clamped to 1 .. MAX_FREQS.
      if (freq_count_ff == '0) begin
         nfreq = 5'd1;
      end else if (DONE_W'(freq_count_ff) > MAX_FREQS_V) begin
         nfreq = MAX_FREQS_V;
      end else begin
         nfreq = DONE_W'(freq_count_ff);
      end
      fidx_inc   = DONE_W'(freq_index_ff) + 5'd1;
      fidx_after = (fidx_inc >= nfreq) ? '0 : fidx_inc;
      done_inc   = (done_count_ff < DONE_SAT) ? done_count_ff + 5'd1 : done_count_ff;

      // Defaults: state holds.
      active_in      = active_ff;
      level_in       = level_ff;
      trial_count_in = trial_count_ff;
      down_now_in    = down_now_ff;
      down_before_in = down_before_ff;
      reversal_in    = reversal_ff;
      wrong_run_in   = wrong_run_ff;
      freq_index_in  = freq_index_ff;
      right_in       = right_ff;
      done_count_in  = done_count_ff;

      out_item_in                 = '0;
      out_item_in.trial_level     = level_ff;
      out_item_in.next_level      = level_ff;
      out_item_in.freq_position   = POS_W'(DONE_W'(freq_index_ff));
      out_item_in.channel_right   = right_ff;

      if (in_item_ff.kind == KIND_START) begin
         // Re-arm from scratch, also in the middle of a test.
         active_in      = 1'b1;
         level_in       = top_level_ff;
         trial_count_in = '0;
         down_now_in    = 1'b1;
         down_before_in = 1'b1;
         reversal_in    = '0;
         wrong_run_in   = '0;
         freq_index_in  = '0;
         right_in       = 1'b0;
         done_count_in  = '0;
         out_item_in.accepted      = 1'b1;
         out_item_in.trial_level   = top_level_ff;
         out_item_in.next_level    = top_level_ff;
         out_item_in.freq_position = '0;
         out_item_in.channel_right = 1'b0;
      end else if (active_ff) begin
         wrong_run_in   = run_next;
         down_now_in    = moved_down;
         down_before_in = moved_down;
         out_item_in.accepted        = 1'b1;
         out_item_in.answer_correct  = correct;
         out_item_in.trial_level     = level_ff;
         out_item_in.completed_count = done_count_ff;
         if (freq_end) begin
            level_in       = top_level_ff;
            trial_count_in = '0;
            reversal_in    = '0;
            done_count_in  = done_inc;
            freq_index_in  = FIDX_W'(fidx_after);
            out_item_in.frequency_done  = 1'b1;
            out_item_in.threshold_level = THRESH_W'(moved_level) + THRESH_W'(moved_down);
            out_item_in.completed_count = done_inc;
            out_item_in.next_level      = top_level_ff;
            out_item_in.freq_position   = POS_W'(fidx_after);
            out_item_in.channel_right   = right_ff;
            if (fidx_inc >= nfreq) begin
               if (!right_ff) begin
                  right_in = 1'b1;
                  out_item_in.channel_right = 1'b1;
               end else begin
                  // Both ears finished: report and fall back to idle.
                  active_in     = 1'b0;
                  right_in      = 1'b0;
                  done_count_in = '0;
                  out_item_in.channel_right = 1'b0;
                  out_item_in.test_done     = 1'b1;
               end
            end
         end else begin
            level_in       = moved_level;
            trial_count_in = trial_next;
            reversal_in    = moved_reversal;
            out_item_in.next_level = moved_level;
         end
      end
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         top_level_ff      <= TOP_LEVEL_RESET;
         floor_level_ff    <= FLOOR_LEVEL_RESET;
         trial_limit_ff    <= TRIAL_LIMIT_RESET;
         reversal_limit_ff <= REVERSAL_LIMIT_RESET;
         wrong_run_en_ff   <= WRONG_RUN_EN_RESET;
         freq_count_ff     <= FREQ_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TOP_LEVEL:      top_level_ff      <= csr_write_data[LEVEL_W-1:0];
            CSR_FLOOR_LEVEL:    floor_level_ff    <= csr_write_data[LEVEL_W-1:0];
            CSR_TRIAL_LIMIT:    trial_limit_ff    <= csr_write_data[TRIAL_W-1:0];
            CSR_REVERSAL_LIMIT: reversal_limit_ff <= csr_write_data[REV_LIMIT_W-1:0];
            CSR_WRONG_RUN_EN:   wrong_run_en_ff   <= csr_write_data[0];
            CSR_FREQ_COUNT:     freq_count_ff     <= csr_write_data[FCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         level_ff       <= TOP_LEVEL_RESET;
         trial_count_ff <= '0;
         down_now_ff    <= 1'b1;
         down_before_ff <= 1'b1;
         reversal_ff    <= '0;
         wrong_run_ff   <= '0;
         freq_index_ff  <= '0;
         right_ff       <= 1'b0;
         done_count_ff  <= '0;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (stage_take) begin
            active_ff      <= active_in;
            level_ff       <= level_in;
            trial_count_ff <= trial_count_in;
            down_now_ff    <= down_now_in;
            down_before_ff <= down_before_in;
            reversal_ff    <= reversal_in;
            wrong_run_ff   <= wrong_run_in;
            freq_index_ff  <= freq_index_in;
            right_ff       <= right_in;
            done_count_ff  <= done_count_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind            <= req_kind;
         in_item_ff.asked_option    <= req_asked_option;
         in_item_ff.response_option <= req_response_option;
      end
      if (stage_take) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_accepted        = out_item_ff.accepted;
   assign rsp_answer_correct  = out_item_ff.answer_correct;
   assign rsp_trial_level     = out_item_ff.trial_level;
   assign rsp_next_level      = out_item_ff.next_level;
   assign rsp_frequency_done  = out_item_ff.frequency_done;
   assign rsp_threshold_level = out_item_ff.threshold_level;
   assign rsp_freq_position   = out_item_ff.freq_position;
   assign rsp_channel_right   = out_item_ff.channel_right;
   assign rsp_test_done       = out_item_ff.test_done;
   assign rsp_completed_count = out_item_ff.completed_count;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_idle_counts_clear: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (trial_count_ff == '0) && (done_count_ff == '0))
      else $error("counters not clear while idle");

   a_freq_index_range: assert property (@(posedge clock) disable iff (reset)
      DONE_W'(freq_index_ff) < MAX_FREQS_V)
      else $error("frequency index out of range");

   a_test_done_ends_freq: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.test_done |-> out_item_ff.frequency_done && !active_ff)
      else $error("test finished without ending a frequency or going idle");

   a_stalled_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |=> in_valid_ff)
      else $error("input transaction lost while the result was stalled");

   a_ignored_trial_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.accepted |->
         !out_item_ff.frequency_done && !out_item_ff.answer_correct)
      else $error("ignored trial reported progress");

endmodule

// ===== dv/audiometry_staircase_sequencer_checker.sv =====
`timescale 1ns / 1ps

module audiometry_staircase_sequencer_checker
   import stair_pkg::*;
#(
   parameter int MAX_FREQS = MAX_FREQS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,

   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_kind,
   input  logic [OPTION_W-1:0]    req_asked_option,
   input  logic [OPTION_W-1:0]    req_response_option,

   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_accepted,
   input  logic                   rsp_answer_correct,
   input  logic [LEVEL_W-1:0]     rsp_trial_level,
   input  logic [LEVEL_W-1:0]     rsp_next_level,
   input  logic                   rsp_frequency_done,
   input  logic [THRESH_W-1:0]    rsp_threshold_level,
   input  logic [POS_W-1:0]       rsp_freq_position,
   input  logic                   rsp_channel_right,
   input  logic                   rsp_test_done,
   input  logic [DONE_W-1:0]      rsp_completed_count,

   output int unsigned            mismatch_count,
   output int unsigned            pending_count,
   output int unsigned            acted_count,
   output int unsigned            freq_end_count,
   output int unsigned            test_end_count,
   output bit                     armed
);

   // Register copies.
   logic [LEVEL_W-1:0]     cfg_top;
   logic [LEVEL_W-1:0]     cfg_floor;
   logic [TRIAL_W-1:0]     cfg_trial_limit;
   logic [REV_LIMIT_W-1:0] cfg_rev_limit;
   logic                   cfg_wrong_run_en;
   logic [FCOUNT_W-1:0]    cfg_freq_count;

   // Staircase state.
   logic                   st_active;
   logic [LEVEL_W-1:0]     st_level;
   logic [TRIAL_W-1:0]     st_trials;
   logic                   st_down_now;
   logic                   st_down_before;
   // Kept at 32 bits: with a reversal limit below two the count wraps below
   // zero, and from there it neither climbs nor meets the limit again.
   int unsigned            st_reversals;
   logic [RUN_W-1:0]       st_wrong_run;
   logic [4:0]             st_freq_idx;
   logic                   st_right;
   logic [DONE_W-1:0]      st_done;

   rsp_item_type           expected_results[$];
   int unsigned            mismatches;
   int unsigned            acted;
   int unsigned            freq_ends;
   int unsigned            test_ends;

   function automatic void rearm();
      st_level       = cfg_top;
      st_trials      = '0;
      st_down_now    = 1'b1;
      st_down_before = 1'b1;
      st_reversals   = 0;
      st_wrong_run   = '0;
      st_freq_idx    = '0;
      st_right       = 1'b0;
      st_done        = '0;
   endfunction

   function automatic rsp_item_type staircase_step(input req_item_type item);
      rsp_item_type res;
      logic [LEVEL_W-1:0] used_level;
      logic [4:0]         nfreq;
      logic               ends;
      res = '0;
      if (item.kind == KIND_START) begin
         rearm();
         st_active    = 1'b1;
         res.accepted = 1'b1;
      end
      if (item.kind == KIND_START || !st_active) begin
         res.trial_level   = st_level;
         res.next_level    = st_level;
         res.freq_position = st_freq_idx[POS_W-1:0];
         res.channel_right = st_right;
         return res;
      end

      used_level = st_level;
      res.answer_correct = (item.response_option != NO_ANSWER) &&
                           (item.response_option == item.asked_option);
      if (res.answer_correct) begin
         st_wrong_run = '0;
      end else if (st_wrong_run < WRONG_RUN_END) begin
         st_wrong_run = st_wrong_run + 1'b1;
      end
      if (st_trials < TRIAL_SAT) begin
         st_trials = st_trials + 1'b1;
      end

      if (res.answer_correct) begin
         if (st_level > 0) begin
            st_level    = st_level - 1'b1;
            st_down_now = 1'b1;
         end
      end else if (st_level < cfg_top) begin
         st_level    = st_level + 1'b1;
         st_down_now = 1'b0;
      end

      if (st_down_before && !st_down_now) begin
         if (st_reversals < REVERSAL_SAT) begin
            st_reversals = st_reversals + 1;
         end
      end else if (st_down_before && st_down_now) begin
         if (st_reversals + REVERSAL_MARGIN > cfg_rev_limit) begin
            st_reversals = st_reversals - 1;
         end
      end
      st_down_before = st_down_now;

      ends = (st_level <= cfg_floor) || (st_trials >= cfg_trial_limit) ||
             (st_level == 0) || (st_reversals == cfg_rev_limit) ||
             (cfg_wrong_run_en && st_wrong_run >= WRONG_RUN_END);
      if (ends) begin
         res.frequency_done  = 1'b1;
         res.threshold_level = {1'b0, st_level} + st_down_now;
         if (st_done < DONE_SAT) begin
            st_done = st_done + 1'b1;
         end
         res.completed_count = st_done;
         st_freq_idx  = st_freq_idx + 1'b1;
         st_level     = cfg_top;
         st_trials    = '0;
         st_reversals = 0;
         nfreq = (cfg_freq_count == 0) ? 5'd1 : 5'(cfg_freq_count);
         if (nfreq > MAX_FREQS) begin
            nfreq = 5'(MAX_FREQS);
         end
         if (st_freq_idx >= nfreq) begin
            st_freq_idx = '0;
            if (!st_right) begin
               st_right = 1'b1;
            end else begin
               res.test_done = 1'b1;
               st_active     = 1'b0;
               st_right      = 1'b0;
               st_done       = '0;
            end
         end
      end else begin
         res.completed_count = st_done;
      end

      res.accepted      = 1'b1;
      res.trial_level   = used_level;
      res.next_level    = st_level;
      res.freq_position = st_freq_idx[POS_W-1:0];
      res.channel_right = st_right;
      return res;
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      req_item_type item;
      if (reset) begin
         cfg_top          = TOP_LEVEL_RESET;
         cfg_floor        = FLOOR_LEVEL_RESET;
         cfg_trial_limit  = TRIAL_LIMIT_RESET;
         cfg_rev_limit    = REVERSAL_LIMIT_RESET;
         cfg_wrong_run_en = WRONG_RUN_EN_RESET;
         cfg_freq_count   = FREQ_COUNT_RESET;
         st_active        = 1'b0;
         rearm();
         expected_results.delete();
         mismatches = 0;
         acted      = 0;
         freq_ends  = 0;
         test_ends  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result transaction arrived with no request outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               compare_field("accepted", want.accepted, rsp_accepted);
               compare_field("answer_correct", want.answer_correct, rsp_answer_correct);
               compare_field("trial_level", want.trial_level, rsp_trial_level);
               compare_field("next_level", want.next_level, rsp_next_level);
               compare_field("frequency_done", want.frequency_done, rsp_frequency_done);
               compare_field("threshold_level", want.threshold_level, rsp_threshold_level);
               compare_field("freq_position", want.freq_position, rsp_freq_position);
               compare_field("channel_right", want.channel_right, rsp_channel_right);
               compare_field("test_done", want.test_done, rsp_test_done);
               compare_field("completed_count", want.completed_count, rsp_completed_count);
            end
         end

         if (csr_write_enable) begin
            case (csr_index)
               CSR_TOP_LEVEL:      cfg_top          = csr_write_data[LEVEL_W-1:0];
               CSR_FLOOR_LEVEL:    cfg_floor        = csr_write_data[LEVEL_W-1:0];
               CSR_TRIAL_LIMIT:    cfg_trial_limit  = csr_write_data[TRIAL_W-1:0];
               CSR_REVERSAL_LIMIT: cfg_rev_limit    = csr_write_data[REV_LIMIT_W-1:0];
               CSR_WRONG_RUN_EN:   cfg_wrong_run_en = csr_write_data[0];
               CSR_FREQ_COUNT:     cfg_freq_count   = csr_write_data[FCOUNT_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            item.kind            = req_kind;
            item.asked_option    = req_asked_option;
            item.response_option = req_response_option;
            want = staircase_step(item);
            expected_results.push_back(want);
            if (want.accepted)       acted++;
            if (want.frequency_done) freq_ends++;
            if (want.test_done)      test_ends++;
         end
      end

      // Published with nonblocking updates so that the stimulus side reads
      // settled values at the same edge.
      mismatch_count <= mismatches;
      pending_count  <= expected_results.size();
      acted_count    <= acted;
      freq_end_count <= freq_ends;
      test_end_count <= test_ends;
      armed          <= st_active;
   end

endmodule

// ===== dv/audiometry_staircase_sequencer_top_test.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the staircase sequencer. The checker instantiated
// beside the block does all prediction and comparison; this module only makes
// transactions, applies back-pressure and decides the outcome.
module audiometry_staircase_sequencer_top_test;
   import stair_pkg::*;

   // Acted-on transactions after which the random part stops opening phases.
   localparam int unsigned ITEM_TARGET = 1550;

   logic                   clock               = 1'b0;
   logic                   reset               = 1'b1;
   logic                   csr_write_enable    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index           = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data      = '0;
   logic                   req_valid           = 1'b0;
   logic                   req_kind            = KIND_START;
   logic [OPTION_W-1:0]    req_asked_option    = '0;
   logic [OPTION_W-1:0]    req_response_option = '0;
   logic                   rsp_stall           = 1'b0;

   logic                   req_stall;
   logic                   rsp_valid;
   logic                   rsp_accepted;
   logic                   rsp_answer_correct;
   logic [LEVEL_W-1:0]     rsp_trial_level;
   logic [LEVEL_W-1:0]     rsp_next_level;
   logic                   rsp_frequency_done;
   logic [THRESH_W-1:0]    rsp_threshold_level;
   logic [POS_W-1:0]       rsp_freq_position;
   logic                   rsp_channel_right;
   logic                   rsp_test_done;
   logic [DONE_W-1:0]      rsp_completed_count;

   int unsigned            mismatch_count;
   int unsigned            pending_count;
   int unsigned            acted_count;
   int unsigned            freq_end_count;
   int unsigned            test_end_count;
   bit                     armed;

   // Each side flips now and then into a calm stretch in which it never idles,
   // so that back-to-back transactions are exercised as well as gaps.
   bit                     sender_calm   = 1'b0;
   bit                     receiver_calm = 1'b0;
   int unsigned            stall_left    = 0;

   always #5 clock = ~clock;

   audiometry_staircase_sequencer_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_asked_option    (req_asked_option),
      .req_response_option (req_response_option),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_answer_correct  (rsp_answer_correct),
      .rsp_trial_level     (rsp_trial_level),
      .rsp_next_level      (rsp_next_level),
      .rsp_frequency_done  (rsp_frequency_done),
      .rsp_threshold_level (rsp_threshold_level),
      .rsp_freq_position   (rsp_freq_position),
      .rsp_channel_right   (rsp_channel_right),
      .rsp_test_done       (rsp_test_done),
      .rsp_completed_count (rsp_completed_count)
   );

   audiometry_staircase_sequencer_checker i_staircase_check (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_asked_option    (req_asked_option),
      .req_response_option (req_response_option),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_answer_correct  (rsp_answer_correct),
      .rsp_trial_level     (rsp_trial_level),
      .rsp_next_level      (rsp_next_level),
      .rsp_frequency_done  (rsp_frequency_done),
      .rsp_threshold_level (rsp_threshold_level),
      .rsp_freq_position   (rsp_freq_position),
      .rsp_channel_right   (rsp_channel_right),
      .rsp_test_done       (rsp_test_done),
      .rsp_completed_count (rsp_completed_count),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count),
      .acted_count         (acted_count),
      .freq_end_count      (freq_end_count),
      .test_end_count      (test_end_count),
      .armed               (armed)
   );

   // Half of all draws give no wait at all; the rest give a wait drawn at
   // random. A calm side never waits.
   function automatic int unsigned pause_length(input bit calm);
      if (calm || $urandom_range(0, 1) == 0) begin
         return 0;
      end
      return $urandom_range(1, 16);
   endfunction

   // Returns one of the two extremes an eighth of the time each, otherwise a
   // value from the whole span, so that every setting sees its corners.
   function automatic int unsigned bounded_pick(input int unsigned lo, input int unsigned hi);
      case ($urandom_range(0, 7))
         0:       return lo;
         1:       return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   // The receiver draws a fresh stall for each result transaction that it
   // takes, and counts it down only while a result is actually waiting, so the
   // stall always lands on a presented result rather than on empty cycles.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 31) == 0) begin
            receiver_calm = !receiver_calm;
         end
         stall_left = pause_length(receiver_calm);
         rsp_stall <= (stall_left != 0);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= (stall_left != 0);
      end
   end

   // Presents one request transaction after a random gap and returns at the
   // edge at which it is taken. When no gap is drawn, valid simply stays high
   // from the previous transaction, so it is never dropped and raised within
   // one time step.
   task automatic present_item(input logic kind, input logic [OPTION_W-1:0] asked,
                               input logic [OPTION_W-1:0] resp);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0) begin
         sender_calm = !sender_calm;
      end
      gap = pause_length(sender_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_asked_option    <= asked;
      req_response_option <= resp;
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender back until every expected result has come out; the
   // block then holds no transaction and its registers may be changed.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Writes all six registers on consecutive edges; the enable stays high
   // across the burst and is lowered once at the end.
   task automatic apply_setting(input int unsigned top, input int unsigned floor,
                                input int unsigned limit, input int unsigned reversals,
                                input int unsigned wrong_run, input int unsigned freqs);
      csr_index_type      idx [6];
      int unsigned        value [6];
      idx   = '{CSR_TOP_LEVEL, CSR_FLOOR_LEVEL, CSR_TRIAL_LIMIT,
                CSR_REVERSAL_LIMIT, CSR_WRONG_RUN_EN, CSR_FREQ_COUNT};
      value = '{top, floor, limit, reversals, wrong_run, freqs};
      foreach (idx[i]) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[i];
         csr_write_data   <= CSR_DATA_W'(value[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // One random phase. Most transactions are well-formed trials of a running
   // test with a phase-wide chance of a correct answer, so that frequencies and
   // whole tests run to their end; the rest are starts while idle, re-arms in
   // mid-test, ignored trials while idle and answers with any option code at all.
   task automatic run_phase();
      int unsigned         count;
      int unsigned         correct_pct;
      logic                kind;
      logic [OPTION_W-1:0] asked;
      logic [OPTION_W-1:0] resp;
      count       = $urandom_range(30, 120);
      correct_pct = $urandom_range(5, 95);
      repeat (count) begin
         if (!armed) begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_TRIAL : KIND_START;
         end else begin
            kind = ($urandom_range(0, 49) == 0) ? KIND_START : KIND_TRIAL;
         end
         asked = OPTION_W'($urandom_range(0, 2));
         if ($urandom_range(0, 19) == 0) begin
            asked = OPTION_W'($urandom());
            resp  = OPTION_W'($urandom());
         end else if ($urandom_range(1, 100) <= correct_pct) begin
            resp = asked;
         end else if ($urandom_range(0, 3) == 0) begin
            resp = NO_ANSWER;
         end else begin
            resp = OPTION_W'((asked + $urandom_range(1, 2)) % 3);
         end
         present_item(kind, asked, resp);
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned top;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset settings. A trial before any start is
      // ignored; the asked slot of three matches nothing either.
      present_item(KIND_TRIAL, 2'd3, NO_ANSWER);
      present_item(KIND_START, 2'd0, 2'd0);
      // Correct answers on every slot walk the level down.
      present_item(KIND_TRIAL, 2'd0, 2'd0);
      present_item(KIND_TRIAL, 2'd1, 2'd1);
      present_item(KIND_TRIAL, 2'd2, 2'd2);
      // No answer, then an invalid asked slot, both count as wrong and turn
      // the staircase upwards: a reversal.
      present_item(KIND_TRIAL, 2'd2, NO_ANSWER);
      present_item(KIND_TRIAL, 2'd3, NO_ANSWER);
      present_item(KIND_TRIAL, 2'd1, 2'd1);
      present_item(KIND_TRIAL, 2'd0, 2'd2);
      // A start in mid-test re-arms everything; eight correct answers then
      // reach level zero, which is also the floor, and end the frequency.
      present_item(KIND_START, 2'd3, 2'd3);
      repeat (8) present_item(KIND_TRIAL, 2'd2, 2'd2);

      // Lowering the top level under a running test leaves the level above
      // it, so wrong answers cannot raise it; three wrong in a row then end the
      // frequency with the run check switched on.
      wait_quiet();
      apply_setting(4, 0, 50, 3, 1, 4);
      present_item(KIND_TRIAL, 2'd1, 2'd0);
      present_item(KIND_TRIAL, 2'd0, NO_ANSWER);
      present_item(KIND_TRIAL, 2'd2, 2'd1);

      // A trial limit of zero ends every trial, and a frequency count of zero
      // acts as one, so two trials finish the left ear and then the whole test.
      wait_quiet();
      apply_setting(4, 0, 0, 3, 0, 0);
      present_item(KIND_TRIAL, 2'd1, 2'd1);
      present_item(KIND_TRIAL, 2'd0, NO_ANSWER);
      present_item(KIND_TRIAL, 2'd2, 2'd1);

      // Random phases. The first two force the far corners of the settings;
      // each phase starts only once the block has gone quiet.
      phase = 0;
      while (acted_count < ITEM_TARGET) begin
         wait_quiet();
         case (phase)
            0: apply_setting(15, 0, 63, 15, 0, 15);
            1: apply_setting(1, 15, 1, 2, 1, 1);
            default: begin
               top = bounded_pick(0, 15);
               apply_setting(top,
                             ($urandom_range(0, 3) == 0) ? bounded_pick(0, 15)
                                                         : $urandom_range(0, top / 2),
                             bounded_pick(0, 63), bounded_pick(0, 15),
                             $urandom_range(0, 1), bounded_pick(0, 15));
            end
         endcase
         run_phase();
         phase++;
      end

      wait_quiet();
      repeat (8) @(posedge clock);
      $display("Run covered %0d acted-on transactions over %0d setting phases,",
               acted_count, phase);
      $display("finishing %0d frequencies and %0d complete two-ear tests.",
               freq_end_count, test_end_count);
      if (mismatch_count == 0) begin
         $display("audiometry_staircase_sequencer_top: match");
      end else begin
         $display("audiometry_staircase_sequencer_top: mismatch");
      end
      $finish;
   end

   // A correct run needs well under a tenth of this time.
   initial begin
      #10ms;
      $display("Run timed out with %0d results still expected.", pending_count);
      $display("audiometry_staircase_sequencer_top: mismatch");
      $finish;
   end

endmodule
